// ----- rtl/wrsi_pkg.sv -----
// Shared types, widths and constants for the Wilder RSI stream block.
package wrsi_pkg;

    // Field and datapath widths.
    localparam int PRICE_W  = 32;
    localparam int PERIOD_W = 7;
    localparam int FRAC_W   = 16;
    localparam int AVG_W    = 56;
    localparam int MOVE_W   = PRICE_W + FRAC_W;
    localparam int RSI_W    = 23;
    localparam int SCALE_W  = 7;
    localparam int DQ_W     = AVG_W + PERIOD_W;
    localparam int REM_W    = AVG_W + 1;
    localparam int STEP_W   = 6;

    // Low bits of the scaled gain that still belong to the quotient field.
    localparam int RSI_LOW  = RSI_W - FRAC_W;

    // RSI of 100.0 in Q7.16 and the integer scale that produces it.
    localparam logic [RSI_W-1:0]    RSI_FULL     = 23'd6553600;
    localparam logic [SCALE_W-1:0]  RSI_SCALE    = 7'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;

    // Divider step counts for the average update and for the ratio.
    localparam logic [STEP_W-1:0] AVG_DIV_STEPS = 6'd63;
    localparam logic [STEP_W-1:0] RSI_DIV_STEPS = 6'd23;

    typedef logic [PRICE_W-1:0]  price_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [AVG_W-1:0]    avg_t;
    typedef logic [MOVE_W-1:0]   move_t;
    typedef logic [RSI_W-1:0]    rsi_t;
    typedef logic [DQ_W-1:0]     dq_t;
    typedef logic [REM_W-1:0]    rem_t;
    typedef logic [STEP_W-1:0]   step_t;

    // Commands from the sequencer to the shared divider.
    typedef struct packed {
        logic load;
        logic run;
    } div_ctl_t;

endpackage

// ----- rtl/wrsi_in_if.sv -----
// Input channel: one closing price word with its restart flag.
interface wrsi_in_if;
    import wrsi_pkg::*;

    logic   valid;
    logic   ready;
    price_t close_price;
    logic   restart;

    modport source (output valid, output close_price, output restart, input ready);
    modport sink   (input valid, input close_price, input restart, output ready);
endinterface

// ----- rtl/wrsi_out_if.sv -----
// Output channel: one RSI word with its valid flag.
interface wrsi_out_if;
    import wrsi_pkg::*;

    logic valid;
    logic ready;
    rsi_t rsi_value;
    logic rsi_valid;

    modport source (output valid, output rsi_value, output rsi_valid, input ready);
    modport sink   (input valid, input rsi_value, input rsi_valid, output ready);
endinterface

// ----- rtl/wrsi_cfg_if.sv -----
// Configuration channel: one period word per write.
interface wrsi_cfg_if;
    import wrsi_pkg::*;

    logic    valid;
    logic    ready;
    period_t period;

    modport source (output valid, output period, input ready);
    modport sink   (input valid, input period, output ready);
endinterface

// ----- rtl/wrsi_div_unit.sv -----
// Shared restoring divider, one quotient bit per cycle while run is asserted.
module wrsi_div_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  wrsi_pkg::div_ctl_t ctl,
    input  wrsi_pkg::dq_t    load_dq,
    input  wrsi_pkg::rem_t   load_rem,
    input  wrsi_pkg::rem_t   load_div,
    input  wrsi_pkg::step_t  load_steps,
    output wrsi_pkg::dq_t    dq,
    output logic             last
);
    import wrsi_pkg::*;

    rem_t  rem_reg;
    rem_t  div_reg;
    dq_t   dq_reg;
    step_t step_reg;

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           fits;
    rem_t           rem_next;
    dq_t            dq_next;

    // One trial subtraction: shift the next dividend bit into the remainder.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[DQ_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
        dq_next  = {dq_reg[DQ_W-2:0], fits};
    end

    assign dq   = dq_reg;
    assign last = (step_reg == STEP_W'(1));

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (ctl.load)
        begin
            step_reg <= load_steps;
        end
        else if (ctl.run)
        begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // Remainder, divisor and dividend/quotient register.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg <= load_rem;
            div_reg <= load_div;
            dq_reg  <= load_dq;
        end
        else if (ctl.run)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

endmodule

// ----- rtl/wilder_rsi_stream.sv -----
// Wilder RSI stream top level: sequencer, series state and output register.
// First close of a series: no division. While the window fills the moves are summed, the
// close that fills it divides both sums by the period, and each later close smooths them
// as ((period - 1) * avg + move) / period. Closes are taken one at a time; the shared
// one-bit-per-cycle divider (63 steps per average, 23 steps for the ratio) sets the pace.
// Reset: asynchronous active low; period returns to 14 and the series state to zero.
module wilder_rsi_stream #(
    parameter int MAX_PERIOD = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    wrsi_in_if.sink    price_ch,
    wrsi_out_if.source rsi_ch,
    wrsi_cfg_if.sink   cfg_ch
);
    import wrsi_pkg::*;

    localparam int CNT_W = $clog2(MAX_PERIOD + 2);
    localparam int CMP_W = ((CNT_W > PERIOD_W) ? CNT_W : PERIOD_W) + 1;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_PREP  = 17'h00002,
        S_ACC   = 17'h00004,
        S_LOADG = 17'h00008,
        S_MULG  = 17'h00010,
        S_ADDG  = 17'h00020,
        S_DIVG  = 17'h00040,
        S_SAVG  = 17'h00080,
        S_LOADL = 17'h00100,
        S_MULL  = 17'h00200,
        S_ADDL  = 17'h00400,
        S_DIVL  = 17'h00800,
        S_SAVL  = 17'h01000,
        S_RSI   = 17'h02000,
        S_DIVR  = 17'h04000,
        S_SAVR  = 17'h08000,
        S_DONE  = 17'h10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    period_t            period_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               init_reg;
    price_t             prev_reg;
    avg_t               gain_reg;
    avg_t               loss_reg;

    price_t price_reg;
    logic   restart_reg;
    move_t  move_g_reg;
    move_t  move_l_reg;
    rsi_t   res_value_reg;
    logic   res_flag_reg;
    logic   out_valid_reg;
    rsi_t   out_value_reg;
    logic   out_flag_reg;

    period_t          p_eff;
    period_t          p_minus1;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] p_ext;
    logic             cnt_zero;
    logic             window_full;
    logic             price_up;
    price_t           mag;
    avg_t             mul_a;
    logic [SCALE_W-1:0] mul_b;
    dq_t              prod;
    rem_t             gain_sum;
    rem_t             loss_sum;
    avg_t             gain_acc;
    avg_t             loss_acc;
    avg_t             dq_sat;
    rsi_t             rsi_q;
    rsi_t             rsi_clamped;
    logic             in_take;
    logic             cfg_take;
    logic             out_load;

    div_ctl_t div_ctl;
    dq_t      div_load_dq;
    rem_t     div_load_rem;
    rem_t     div_load_div;
    step_t    div_load_steps;
    dq_t      div_dq;
    logic     div_last;

    wrsi_div_unit u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (div_ctl),
        .load_dq    (div_load_dq),
        .load_rem   (div_load_rem),
        .load_div   (div_load_div),
        .load_steps (div_load_steps),
        .dq         (div_dq),
        .last       (div_last)
    );

    // Handshakes.
    assign price_ch.ready = (state_reg == S_IDLE);
    assign cfg_ch.ready   = 1'b1;
    assign in_take        = price_ch.valid && price_ch.ready;
    assign cfg_take       = cfg_ch.valid && cfg_ch.ready;
    assign out_load       = (state_reg == S_DONE) && (!out_valid_reg || rsi_ch.ready);

    assign rsi_ch.valid     = out_valid_reg;
    assign rsi_ch.rsi_value = out_value_reg;
    assign rsi_ch.rsi_valid = out_flag_reg;

    // Effective period, clamped to the supported range; zero acts as one.
    always_comb
    begin
        if (period_reg == '0)
        begin
            p_eff = PERIOD_W'(1);
        end
        else if (int'(period_reg) > MAX_PERIOD)
        begin
            p_eff = PERIOD_W'(MAX_PERIOD);
        end
        else
        begin
            p_eff = period_reg;
        end
    end

    assign p_minus1    = p_eff - PERIOD_W'(1);
    assign count_ext   = CMP_W'(count_reg);
    assign p_ext       = CMP_W'(p_eff);
    assign cnt_zero    = restart_reg || (count_reg == '0);
    assign window_full = count_ext > p_ext;

    // Price move as a magnitude and direction.
    assign price_up = price_reg >= prev_reg;
    assign mag      = price_up ? (price_reg - prev_reg) : (prev_reg - price_reg);

    // Shared multiplier: average times (period - 1), or gain times the RSI scale.
    assign mul_a = (state_reg == S_MULL) ? loss_reg : gain_reg;
    assign mul_b = (state_reg == S_RSI) ? RSI_SCALE : SCALE_W'(p_minus1);
    assign prod  = dq_t'(mul_a) * dq_t'(mul_b);

    // Saturating sums used while the window fills.
    assign gain_sum = rem_t'(gain_reg) + rem_t'(move_g_reg);
    assign loss_sum = rem_t'(loss_reg) + rem_t'(move_l_reg);
    assign gain_acc = gain_sum[AVG_W] ? '1 : gain_sum[AVG_W-1:0];
    assign loss_acc = loss_sum[AVG_W] ? '1 : loss_sum[AVG_W-1:0];

    // Quotient post-processing.
    assign dq_sat      = (|div_dq[DQ_W-1:AVG_W]) ? '1 : div_dq[AVG_W-1:0];
    assign rsi_q       = div_dq[RSI_W-1:0];
    assign rsi_clamped = (rsi_q > RSI_FULL) ? RSI_FULL : rsi_q;

    // Divider command and operand selection.
    always_comb
    begin
        div_ctl        = '0;
        div_load_dq    = dq_t'(gain_reg);
        div_load_rem   = '0;
        div_load_div   = rem_t'(p_eff);
        div_load_steps = AVG_DIV_STEPS;
        unique case (state_reg)
            S_LOADG:
            begin
                div_ctl.load = 1'b1;
            end
            S_MULG, S_MULL:
            begin
                div_ctl.load = 1'b1;
                div_load_dq  = prod;
            end
            S_ADDG:
            begin
                div_ctl.load = 1'b1;
                div_load_dq  = div_dq + dq_t'(move_g_reg);
            end
            S_LOADL:
            begin
                div_ctl.load = 1'b1;
                div_load_dq  = dq_t'(loss_reg);
            end
            S_ADDL:
            begin
                div_ctl.load = 1'b1;
                div_load_dq  = div_dq + dq_t'(move_l_reg);
            end
            S_RSI:
            begin
                // Dividend is (gain * 100) << 16; its top part starts as the remainder.
                div_ctl.load   = 1'b1;
                div_load_rem   = rem_t'(prod[DQ_W-1:RSI_LOW]);
                div_load_dq    = {prod[RSI_LOW-1:0], {(DQ_W-RSI_LOW){1'b0}}};
                div_load_div   = rem_t'(gain_reg) + rem_t'(loss_reg);
                div_load_steps = RSI_DIV_STEPS;
            end
            S_DIVG, S_DIVL, S_DIVR:
            begin
                div_ctl.run = 1'b1;
            end
            default:
            begin
                div_ctl = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (price_ch.valid) state_next = S_PREP;
            S_PREP:
            begin
                if (cnt_zero)
                    state_next = S_RSI;
                else if (count_ext <= p_ext)
                    state_next = S_ACC;
                else
                    state_next = S_MULG;
            end
            S_ACC:   state_next = (count_ext == p_ext) ? S_LOADG : S_RSI;
            S_LOADG: state_next = S_DIVG;
            S_MULG:  state_next = S_ADDG;
            S_ADDG:  state_next = S_DIVG;
            S_DIVG:  if (div_last) state_next = S_SAVG;
            S_SAVG:  state_next = init_reg ? S_LOADL : S_MULL;
            S_LOADL: state_next = S_DIVL;
            S_MULL:  state_next = S_ADDL;
            S_ADDL:  state_next = S_DIVL;
            S_DIVL:  if (div_last) state_next = S_SAVL;
            S_SAVL:  state_next = S_RSI;
            S_RSI:   state_next = (window_full && (loss_reg != '0)) ? S_DIVR : S_DONE;
            S_DIVR:  if (div_last) state_next = S_SAVR;
            S_SAVR:  state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control and series state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= PERIOD_RESET;
            count_reg     <= '0;
            init_reg      <= 1'b0;
            prev_reg      <= '0;
            gain_reg      <= '0;
            loss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // A period write starts a new series.
            if (cfg_take)
            begin
                period_reg <= cfg_ch.period;
                count_reg  <= '0;
                prev_reg   <= '0;
                gain_reg   <= '0;
                loss_reg   <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_PREP:
                    begin
                        prev_reg <= price_reg;
                        init_reg <= 1'b0;
                        if (cnt_zero)
                        begin
                            count_reg <= CNT_W'(1);
                            gain_reg  <= '0;
                            loss_reg  <= '0;
                        end
                    end
                    S_ACC:
                    begin
                        gain_reg  <= gain_acc;
                        loss_reg  <= loss_acc;
                        count_reg <= count_reg + CNT_W'(1);
                        init_reg  <= (count_ext == p_ext);
                    end
                    S_SAVG:  gain_reg <= dq_sat;
                    S_SAVL:  loss_reg <= dq_sat;
                    default: ;
                endcase
            end

            // Output register holds a finished word until it is taken.
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsi_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            price_reg   <= price_ch.close_price;
            restart_reg <= price_ch.restart;
        end

        if (state_reg == S_PREP)
        begin
            move_g_reg <= price_up ? {mag, {FRAC_W{1'b0}}} : '0;
            move_l_reg <= price_up ? '0 : {mag, {FRAC_W{1'b0}}};
        end

        // Result before the ratio: zero when not yet valid, full scale otherwise.
        if (state_reg == S_RSI)
        begin
            res_flag_reg  <= window_full;
            res_value_reg <= window_full ? RSI_FULL : '0;
        end
        else if (state_reg == S_SAVR)
        begin
            res_value_reg <= rsi_clamped;
        end

        if (out_load)
        begin
            out_value_reg <= res_value_reg;
            out_flag_reg  <= res_flag_reg;
        end
    end

endmodule

// ----- rtl/wrsi_checker.sv -----
// Port-level assertions for the Wilder RSI stream block, with their bind.
module wrsi_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input wrsi_pkg::rsi_t rsi_value,
    input logic          rsi_valid
);
    import wrsi_pkg::*;

    // The block works on one word at a time: it is busy right after taking one.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while the previous word was still in work");

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rsi_value) && $stable(rsi_valid))
        else $error("result word changed or dropped while stalled");

    // A result that is not yet valid carries zero.
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rsi_valid |-> rsi_value == '0)
        else $error("nonzero RSI on a word not yet valid");

    // RSI never exceeds 100.0.
    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rsi_value <= RSI_FULL)
        else $error("RSI above full scale");

endmodule

bind wilder_rsi_stream wrsi_checker u_wrsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (price_ch.valid),
    .in_ready  (price_ch.ready),
    .out_valid (rsi_ch.valid),
    .out_ready (rsi_ch.ready),
    .rsi_value (rsi_ch.rsi_value),
    .rsi_valid (rsi_ch.rsi_valid)
);
